[src/ktea_pkg.sv]
`default_nettype none

package ktea_pkg;

  // fixed field widths of the item and result ports
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned INFO_W    = 64;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CNT_OUT_W = 5;

  // expiry timeout after reset, in milliseconds
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 48'd10000;

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_PRUNE  = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    UPS_UNCHANGED = 2'd0,
    UPS_UPDATED   = 2'd1,
    UPS_ADDED     = 2'd2,
    UPS_REPLACED  = 2'd3
  } upsert_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GET
  } ctl_state_e;

endpackage

`default_nettype wire

[src/ktea_store.sv]
`default_nettype none

module ktea_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 176
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // single read port, registered data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/keyed_table_with_eviction_and_ageing_top.sv]
`default_nettype none

// Keyed table with oldest-entry eviction and ageing.
// Command channel: an item (opcode, key, info, now, index) is taken at a rising
// edge with start high and busy low. busy stays high while the item is in work.
// Result channel: result_valid_o is high for exactly one cycle with all result
// fields; the receiver cannot stall it, so results are never held back.
// Config channel: cfg_valid_i/cfg_ready_o write the expiry timeout; ready is
// always high and writes are meant to happen while the block is idle.
// Item flow, from the accepting edge to the strobe cycle:
//   upsert with empty key, unknown opcode, get out of range: no table access
//   get: one registered table read
//   upsert: scans up to the matching entry on a hit, else all entries, then adds or replaces
//   prune: scans all entries
// The table is one memory with one read and one write port; a scan reads one
// entry per cycle, and prune compaction writes kept entries back in the same pass.
// Reset clears occupancy to zero and the timeout to 10000 ms; table contents
// are not cleared, since no entry at or above occupancy is ever read.
module keyed_table_with_eviction_and_ageing_top
  import ktea_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [KEY_W-1:0]     device_key_i,
  input  wire logic [INFO_W-1:0]    device_info_i,
  input  wire logic [TIME_W-1:0]    now_time_i,
  input  wire logic [IDX_W-1:0]     entry_index_i,
  // config channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [TIME_W-1:0]    cfg_data_i,
  // result channel
  output logic                      result_valid_o,
  output logic [1:0]                upsert_status_o,
  output logic [CNT_OUT_W-1:0]      removed_count_o,
  output logic                      entry_found_o,
  output logic [KEY_W-1:0]          entry_key_o,
  output logic [INFO_W-1:0]         entry_info_o,
  output logic [TIME_W-1:0]         entry_time_o,
  output logic [CNT_OUT_W-1:0]      occupancy_o
);

  localparam int unsigned TW   = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW   = KEY_W + INFO_W + TW;
  localparam int unsigned CMPW = IDX_W + 1;

  ctl_state_e state_q, state_d;

  // latched command
  op_e              op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [INFO_W-1:0] info_q, info_d;
  logic [TW-1:0]    now_q, now_d;

  // scan control
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             rdv_q, rdv_d;
  logic [AW-1:0]    ridx_q, ridx_d;
  logic [CW-1:0]    wr_q, wr_d;
  logic [TW-1:0]    min_q, min_d;
  logic [AW-1:0]    victim_q, victim_d;

  // table occupancy and timeout
  logic [CW-1:0]    fill_q, fill_d;
  logic [TIME_W-1:0] timeout_q;

  // result register
  logic              res_valid_q, res_valid_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [CNT_OUT_W-1:0] res_removed_q, res_removed_d;
  logic              res_found_q, res_found_d;
  logic [KEY_W-1:0]  res_key_q, res_key_d;
  logic [INFO_W-1:0] res_info_q, res_info_d;
  logic [TIME_W-1:0] res_time_q, res_time_d;
  logic [CNT_OUT_W-1:0] res_occ_q, res_occ_d;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic              accept;
  logic              get_in_range;
  logic              issue;
  logic              hit;
  logic              aged;
  logic [KEY_W-1:0]  rd_key;
  logic [INFO_W-1:0] rd_info;
  logic [TW-1:0]     rd_time;
  logic [TW-1:0]     age;

  ktea_store #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared compare unit on the entry read back from the table
  assign rd_key  = mem_rdata[EW-1 -: KEY_W];
  assign rd_info = mem_rdata[TW +: INFO_W];
  assign rd_time = mem_rdata[TW-1:0];
  assign age     = now_q - rd_time;
  assign aged    = (now_q >= rd_time) && (TIME_W'(age) >= timeout_q);
  assign hit     = rd_key == key_q;

  assign busy         = state_q != ST_IDLE;
  assign accept       = start && !busy;
  assign cfg_ready_o  = 1'b1;
  assign issue        = ptr_q < fill_q;
  assign get_in_range = {1'b0, entry_index_i} < CMPW'(fill_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((op_e'(opcode_i) == OP_UPSERT && device_key_i != '0) ||
              op_e'(opcode_i) == OP_PRUNE) begin
            state_d = ST_SCAN;
          end else if (op_e'(opcode_i) == OP_GET && get_in_range) begin
            state_d = ST_GET;
          end
        end
      end
      ST_SCAN: begin
        if ((op_q == OP_UPSERT && rdv_q && hit) || (!issue && !rdv_q)) begin
          state_d = ST_IDLE;
        end
      end
      ST_GET: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and table control
  always_comb begin
    op_d          = op_q;
    key_d         = key_q;
    info_d        = info_q;
    now_d         = now_q;
    ptr_d         = ptr_q;
    rdv_d         = 1'b0;
    ridx_d        = ridx_q;
    wr_d          = wr_q;
    min_d         = min_q;
    victim_d      = victim_q;
    fill_d        = fill_q;
    res_valid_d   = 1'b0;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    res_found_d   = res_found_q;
    res_key_d     = res_key_q;
    res_info_d    = res_info_q;
    res_time_d    = res_time_q;
    res_occ_d     = res_occ_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_q[AW-1:0];
    mem_wdata     = {key_q, info_q, now_q};
    mem_re        = 1'b0;
    mem_raddr     = ptr_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d   = op_e'(opcode_i);
          key_d  = device_key_i;
          info_d = device_info_i;
          now_d  = now_time_i[TW-1:0];
          ptr_d  = '0;
          wr_d   = '0;
          // get reads the entry right away
          mem_re    = op_e'(opcode_i) == OP_GET && get_in_range;
          mem_raddr = entry_index_i[AW-1:0];
          // items that finish without a table access
          if ((op_e'(opcode_i) == OP_UPSERT && device_key_i == '0) ||
              op_e'(opcode_i) == OP_NONE ||
              (op_e'(opcode_i) == OP_GET && !get_in_range)) begin
            res_valid_d   = 1'b1;
            res_status_d  = UPS_UNCHANGED;
            res_removed_d = '0;
            res_found_d   = 1'b0;
            res_key_d     = '0;
            res_info_d    = '0;
            res_time_d    = '0;
            res_occ_d     = CNT_OUT_W'(fill_q);
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, data is checked in the next cycle
        if (issue) begin
          mem_re = 1'b1;
          ptr_d  = CW'(ptr_q + 1'b1);
          rdv_d  = 1'b1;
          ridx_d = ptr_q[AW-1:0];
        end
        res_removed_d = '0;
        res_found_d   = 1'b0;
        res_key_d     = '0;
        res_info_d    = '0;
        res_time_d    = '0;

        if (op_q == OP_UPSERT) begin
          if (rdv_q && hit) begin
            // refresh the matching entry
            mem_we       = 1'b1;
            mem_waddr    = ridx_q;
            rdv_d        = 1'b0;
            res_valid_d  = 1'b1;
            res_status_d = (rd_info != info_q) ? UPS_UPDATED : UPS_UNCHANGED;
            res_occ_d    = CNT_OUT_W'(fill_q);
          end else begin
            // track the oldest entry, lowest index on a tie
            if (rdv_q && (ridx_q == '0 || rd_time < min_q)) begin
              min_d    = rd_time;
              victim_d = ridx_q;
            end
            if (!issue && !rdv_q) begin
              mem_we      = 1'b1;
              res_valid_d = 1'b1;
              if (fill_q < CW'(TABLE_DEPTH)) begin
                mem_waddr    = fill_q[AW-1:0];
                fill_d       = CW'(fill_q + 1'b1);
                res_status_d = UPS_ADDED;
              end else begin
                mem_waddr    = victim_q;
                res_status_d = UPS_REPLACED;
              end
              res_occ_d = CNT_OUT_W'(fill_d);
            end
          end
        end else begin
          // prune: write kept entries back in order
          res_status_d = UPS_UNCHANGED;
          if (rdv_q && !aged) begin
            mem_we    = 1'b1;
            mem_waddr = wr_q[AW-1:0];
            mem_wdata = mem_rdata;
            wr_d      = CW'(wr_q + 1'b1);
          end
          if (!issue && !rdv_q) begin
            fill_d        = wr_q;
            res_valid_d   = 1'b1;
            res_removed_d = CNT_OUT_W'(fill_q - wr_q);
            res_occ_d     = CNT_OUT_W'(wr_q);
          end
        end
      end

      ST_GET: begin
        res_valid_d   = 1'b1;
        res_status_d  = UPS_UNCHANGED;
        res_removed_d = '0;
        res_found_d   = 1'b1;
        res_key_d     = rd_key;
        res_info_d    = rd_info;
        res_time_d    = TIME_W'(rd_time);
        res_occ_d     = CNT_OUT_W'(fill_q);
      end

      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      timeout_q   <= TIMEOUT_RST;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rdv_q       <= rdv_d;
      res_valid_q <= res_valid_d;
      // config transfer
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    key_q         <= key_d;
    info_q        <= info_d;
    now_q         <= now_d;
    ptr_q         <= ptr_d;
    ridx_q        <= ridx_d;
    wr_q          <= wr_d;
    min_q         <= min_d;
    victim_q      <= victim_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    res_found_q   <= res_found_d;
    res_key_q     <= res_key_d;
    res_info_q    <= res_info_d;
    res_time_q    <= res_time_d;
    res_occ_q     <= res_occ_d;
  end

  assign result_valid_o  = res_valid_q;
  assign upsert_status_o = res_status_q;
  assign removed_count_o = res_removed_q;
  assign entry_found_o   = res_found_q;
  assign entry_key_o     = res_key_q;
  assign entry_info_o    = res_info_q;
  assign entry_time_o    = res_time_q;
  assign occupancy_o     = res_occ_q;

`ifndef NO_ASSERTIONS
  // occupancy never exceeds the table depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

  // the table is only written while an item is in work
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> busy)
    else $error("table write while idle");

  // reported occupancy matches the stored count
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> occupancy_o == CNT_OUT_W'(fill_q))
    else $error("occupancy result disagrees with count");

  // a found entry always comes from the get read cycle
  a_found_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && entry_found_o |-> $past(state_q == ST_GET))
    else $error("entry found outside of get");
`endif

endmodule

`default_nettype wire
